// ----- rtl/assert_macros.svh -----
// assertion macros shared by the range-sum core rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define STS_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define STS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define STS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/sts_pkg.sv -----
// shared types and constants of the segment tree range-sum core
`default_nettype none

package sts_pkg;

   localparam int SUM_BITS     = 42;
   localparam int CNT_BITS     = 11;
   localparam int IDX_BITS     = 10;
   localparam int VAL_BITS     = 32;
   localparam int REQ_TDATA_W  = 64;
   localparam int RSP_TDATA_W  = 48;

   localparam logic [CNT_BITS-1:0] COUNT_RESET = 11'd1024;

   localparam logic OP_SET   = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_RANGE_ERR = 1'b1;

   typedef struct packed {
      logic                       operation;
      logic [IDX_BITS-1:0]        element_index;
      logic signed [VAL_BITS-1:0] new_value;
      logic [IDX_BITS-1:0]        range_left;
      logic [IDX_BITS-1:0]        range_right;
   } req_type;

   typedef struct packed {
      logic                       status;
      logic signed [SUM_BITS-1:0] range_sum;
   } rsp_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

`default_nettype wire

// ----- rtl/sts_node_mem.sv -----
// node sum memory: one write port, one read port with registered data
`default_nettype none

module sts_node_mem #(
   parameter int DEPTH = 2048,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire                          clock,
   input  wire  sts_pkg::mem_ctl_type   ctl,
   input  wire  [ADDR_W-1:0]            waddr,
   input  wire  [ADDR_W-1:0]            raddr,
   input  wire  [sts_pkg::SUM_BITS-1:0] wdata,
   output logic [sts_pkg::SUM_BITS-1:0] rdata
);
   import sts_pkg::*;

   logic [SUM_BITS-1:0] mem [DEPTH];
   logic [SUM_BITS-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[waddr] <= wdata;
      end
      if (ctl.rd_en) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- rtl/sts_walk.sv -----
// tree walk sequencer with the shared sum adder
`default_nettype none
`include "assert_macros.svh"

module sts_walk #(
   parameter int CAPACITY   = 1024,
   parameter int VALUE_BITS = 32,
   localparam int ADDR_W = $clog2(2 * CAPACITY)
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire  [sts_pkg::CNT_BITS-1:0] count,
   input  wire                          start,
   input  wire  sts_pkg::req_type       req,
   output logic                         ready,
   output logic                         res_valid,
   output sts_pkg::rsp_type             res,
   input  wire                          res_take,
   output sts_pkg::mem_ctl_type         mem_ctl,
   output logic [ADDR_W-1:0]            mem_waddr,
   output logic [ADDR_W-1:0]            mem_raddr,
   output logic [sts_pkg::SUM_BITS-1:0] mem_wdata,
   input  wire  [sts_pkg::SUM_BITS-1:0] mem_rdata
);
   import sts_pkg::*;

   localparam int NODE_W  = ADDR_W + 1;
   localparam int IN_BITS = (VALUE_BITS < VAL_BITS) ? VALUE_BITS : VAL_BITS;
   localparam logic [ADDR_W-1:0] LAST_NODE = ADDR_W'(2 * CAPACITY - 1);
   localparam logic [ADDR_W-1:0] ROOT_NODE = ADDR_W'(1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_U_READ,
      ST_U_ADD,
      ST_Q_LEFT,
      ST_Q_RIGHT,
      ST_Q_DRAIN,
      ST_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   node_ff, node_in;
   logic [NODE_W-1:0]   lo_ff, lo_in;
   logic [NODE_W-1:0]   hi_ff, hi_in;
   logic [SUM_BITS-1:0] acc_ff, acc_in;
   logic                pend_ff, pend_in;
   logic                op_ff, op_in;
   logic                err_ff, err_in;
   logic [SUM_BITS-1:0] sum;
   logic [SUM_BITS-1:0] value_ext;
   logic [ADDR_W-1:0]   leaf;

   function automatic logic idx_ok(input logic [IDX_BITS-1:0] x,
                                   input logic [CNT_BITS-1:0] cnt);
      return (32'(x) < 32'(cnt)) && (32'(x) < 32'(CAPACITY));
   endfunction

   // the one shared adder
   assign sum       = acc_ff + mem_rdata;
   assign value_ext = SUM_BITS'(signed'(req.new_value[IN_BITS-1:0]));
   assign leaf      = ADDR_W'(req.element_index) + ADDR_W'(CAPACITY);

   always_comb begin
      state_in  = state_ff;
      node_in   = node_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      acc_in    = pend_ff ? sum : acc_ff;
      pend_in   = 1'b0;
      op_in     = op_ff;
      err_in    = err_ff;
      mem_ctl   = '0;
      mem_waddr = node_ff;
      mem_raddr = node_ff;
      mem_wdata = acc_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_ctl.wr_en = 1'b1;
            mem_wdata     = '0;
            if (node_ff == LAST_NODE) begin
               state_in = ST_IDLE;
            end else begin
               node_in = node_ff + ADDR_W'(1);
            end
         end
         ST_IDLE: begin
            if (start) begin
               op_in  = req.operation;
               acc_in = '0;
               err_in = 1'b0;
               if (req.operation == OP_SET) begin
                  if (!idx_ok(req.element_index, count)) begin
                     err_in   = 1'b1;
                     state_in = ST_DONE;
                  end else begin
                     // leaf write, then climb
                     mem_ctl.wr_en = 1'b1;
                     mem_waddr     = leaf;
                     mem_wdata     = value_ext;
                     acc_in        = value_ext;
                     node_in       = leaf;
                     state_in      = ST_U_READ;
                  end
               end else begin
                  if (!idx_ok(req.range_left, count) ||
                      !idx_ok(req.range_right, count)) begin
                     err_in   = 1'b1;
                     state_in = ST_DONE;
                  end else if (req.range_left > req.range_right) begin
                     state_in = ST_DONE;
                  end else begin
                     lo_in    = NODE_W'(req.range_left) + NODE_W'(CAPACITY);
                     hi_in    = NODE_W'(req.range_right) + NODE_W'(CAPACITY)
                                + NODE_W'(1);
                     state_in = ST_Q_LEFT;
                  end
               end
            end
         end
         ST_U_READ: begin
            mem_ctl.rd_en = 1'b1;
            mem_raddr     = node_ff ^ ADDR_W'(1);
            pend_in       = 1'b1;
            state_in      = ST_U_ADD;
         end
         ST_U_ADD: begin
            mem_ctl.wr_en = 1'b1;
            mem_waddr     = node_ff >> 1;
            mem_wdata     = sum;
            node_in       = node_ff >> 1;
            if ((node_ff >> 1) == ROOT_NODE) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_U_READ;
            end
         end
         ST_Q_LEFT: begin
            if (lo_ff >= hi_ff) begin
               state_in = ST_Q_DRAIN;
            end else begin
               if (lo_ff[0]) begin
                  mem_ctl.rd_en = 1'b1;
                  mem_raddr     = lo_ff[ADDR_W-1:0];
                  pend_in       = 1'b1;
                  lo_in         = lo_ff + NODE_W'(1);
               end
               state_in = ST_Q_RIGHT;
            end
         end
         ST_Q_RIGHT: begin
            // odd right bound: take node hi-1, which is hi with bit 0 cleared
            if (hi_ff[0]) begin
               mem_ctl.rd_en = 1'b1;
               mem_raddr     = {hi_ff[ADDR_W-1:1], 1'b0};
               pend_in       = 1'b1;
            end
            lo_in    = lo_ff >> 1;
            hi_in    = hi_ff >> 1;
            state_in = ST_Q_LEFT;
         end
         ST_Q_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         node_ff  <= '0;
         pend_ff  <= 1'b0;
         err_ff   <= 1'b0;
         op_ff    <= OP_SET;
      end else begin
         state_ff <= state_in;
         node_ff  <= node_in;
         pend_ff  <= pend_in;
         err_ff   <= err_in;
         op_ff    <= op_in;
      end
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      acc_ff <= acc_in;
   end

   assign ready         = (state_ff == ST_IDLE);
   assign res_valid     = (state_ff == ST_DONE);
   assign res.status    = err_ff ? STATUS_RANGE_ERR : STATUS_OK;
   assign res.range_sum = (op_ff == OP_QUERY) ? acc_ff : '0;

   `STS_ASSERT_ALWAYS(a_one_port_op, clock, reset, !(mem_ctl.wr_en && mem_ctl.rd_en), "read and write in one cycle")
   `STS_ASSERT_IMPLIES(a_query_no_write, clock, reset, (state_ff == ST_Q_LEFT || state_ff == ST_Q_RIGHT || state_ff == ST_Q_DRAIN), !mem_ctl.wr_en, "query wrote the store")
   `STS_ASSERT_NEXT(a_climb_continues, clock, reset, (state_ff == ST_U_ADD && (node_ff >> 1) != ROOT_NODE), (state_ff == ST_U_READ && pend_ff == 1'b0), "update walk stopped below root")

endmodule

`default_nettype wire

// ----- rtl/segment_tree_range_sum_core.sv -----
// top level of the segment tree range-sum core
`default_nettype none
`include "assert_macros.svh"

// Range-sum core: keeps CAPACITY signed elements as a tree of 42-bit partial
// sums in one 2*CAPACITY-entry memory. A set transaction writes one element and
// rebuilds the sums on its path to the root; a query transaction returns the
// sum over [range_left, range_right]. Indices at or beyond min(element_count,
// CAPACITY) give status 1 and sum 0; a reversed range gives sum 0, status 0.
// After reset the core zeroes all 2*CAPACITY memory entries, with req_tready
// low. The walk never reads and writes the memory together and has one shared
// adder: each tree level takes a sibling read and then an add and write for a
// set, or a left and then a right bound step for a query. A query stops once
// its bounds meet and then passes a drain step, so short ranges finish
// sooner; errors and reversed ranges go straight to the result. One
// transaction is in work at a time; a finished result waits in the output
// register so the next request can already be accepted.
module segment_tree_range_sum_core #(
   parameter int CAPACITY   = 1024,
   parameter int VALUE_BITS = 32
) (
   input  wire                             clock,
   input  wire                             reset,
   // configuration: element_count
   input  wire                             csr_valid,
   output logic                            csr_ready,
   input  wire  [sts_pkg::CNT_BITS-1:0]    csr_data,
   // request stream
   input  wire                             req_tvalid,
   output logic                            req_tready,
   // element_index[9:0], new_value[41:10], range_left[51:42],
   // range_right[61:52], zero pad [63:62]
   input  wire  [sts_pkg::REQ_TDATA_W-1:0] req_tdata,
   // operation[0]
   input  wire  [0:0]                      req_tuser,
   // response stream
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   // range_sum[41:0], zero pad [47:42]
   output logic [sts_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // status[0]
   output logic [0:0]                      rsp_tuser
);
   import sts_pkg::*;

   localparam int DEPTH  = 2 * CAPACITY;
   localparam int ADDR_W = $clog2(DEPTH);

   logic [CNT_BITS-1:0] count_ff;
   req_type             req;
   rsp_type             res;
   rsp_type             out_ff;
   logic                out_valid_ff;
   logic                eng_ready;
   logic                res_valid;
   logic                res_take;
   logic                start;
   mem_ctl_type         mem_ctl;
   logic [ADDR_W-1:0]   mem_waddr;
   logic [ADDR_W-1:0]   mem_raddr;
   logic [SUM_BITS-1:0] mem_wdata;
   logic [SUM_BITS-1:0] mem_rdata;

   // count register: the user must write it only while the core is idle; the block does not enforce it
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
      end else if (csr_valid) begin
         count_ff <= csr_data;
      end
   end

   // unpack request transaction
   assign req.operation     = req_tuser[0];
   assign req.element_index = req_tdata[9:0];
   assign req.new_value     = req_tdata[41:10];
   assign req.range_left    = req_tdata[51:42];
   assign req.range_right   = req_tdata[61:52];

   assign req_tready = eng_ready;
   assign start      = req_tvalid && eng_ready;

   sts_walk #(
      .CAPACITY   (CAPACITY),
      .VALUE_BITS (VALUE_BITS)
   ) u_walk (
      .clock     (clock),
      .reset     (reset),
      .count     (count_ff),
      .start     (start),
      .req       (req),
      .ready     (eng_ready),
      .res_valid (res_valid),
      .res       (res),
      .res_take  (res_take),
      .mem_ctl   (mem_ctl),
      .mem_waddr (mem_waddr),
      .mem_raddr (mem_raddr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

   sts_node_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock (clock),
      .ctl   (mem_ctl),
      .waddr (mem_waddr),
      .raddr (mem_raddr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   // output register: loads when empty or when its transaction is taken
   assign res_take = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (res_take) begin
         out_valid_ff <= res_valid;
      end
      if (res_take && res_valid) begin
         out_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - SUM_BITS)'(0), out_ff.range_sum};
   assign rsp_tuser  = out_ff.status;

   `STS_ASSERT_NEXT(a_busy_after_accept, clock, reset, (req_tvalid && req_tready), !req_tready, "request taken while busy")
   `STS_ASSERT_IMPLIES(a_error_zero_sum, clock, reset, (rsp_tvalid && rsp_tuser[0] == STATUS_RANGE_ERR), (rsp_tdata == '0), "error response with nonzero sum")

endmodule

`default_nettype wire

// ----- sim/tb_segment_tree_range_sum_core.sv -----
// self-checking testbench for the segment tree range-sum core
`timescale 1ns / 100ps

module tb_segment_tree_range_sum_core;
   import sts_pkg::*;

   localparam int CAPACITY    = 1024;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int PHASE_ITEMS = 200;

   // expected-result tracker: mirrors the element array and the count register,
   // and holds the results still owed by the core in acceptance order
   class range_sum_tracker;
      longint      elem_vals [CAPACITY];
      int unsigned live_count;
      rsp_type     owed_results [$];
      int          mismatches;

      function new();
         foreach (elem_vals[i]) elem_vals[i] = 0;
         live_count = CAPACITY;
         mismatches = 0;
      endfunction

      // count above capacity saturates
      function void set_count(logic [CNT_BITS-1:0] value);
         live_count = (value > CAPACITY) ? CAPACITY : value;
      endfunction

      function bit idle();
         return owed_results.size() == 0;
      endfunction

      // work out the result of one accepted request transaction
      function void note_request(req_type item);
         rsp_type expected;
         longint  acc;
         expected.status    = STATUS_OK;
         expected.range_sum = '0;
         acc = 0;
         if (item.operation == OP_SET) begin
            if (item.element_index >= live_count) begin
               expected.status = STATUS_RANGE_ERR;
            end else begin
               elem_vals[item.element_index] = longint'($signed(item.new_value));
            end
         end else begin
            // bounds check comes ahead of the reversed-range check
            if (item.range_left >= live_count || item.range_right >= live_count) begin
               expected.status = STATUS_RANGE_ERR;
            end else if (item.range_left <= item.range_right) begin
               for (int i = item.range_left; i <= item.range_right; i++) begin
                  acc += elem_vals[i];
               end
               expected.range_sum = acc[SUM_BITS-1:0];
            end
         end
         owed_results.push_back(expected);
      endfunction

      function void check_result(logic [SUM_BITS-1:0] sum, logic status);
         rsp_type expected;
         if (owed_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected result: sum %0d status %0d", $signed(sum), status);
            end
         end else begin
            expected = owed_results.pop_front();
            if (expected.range_sum !== sum || expected.status !== status) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("result mismatch: sum exp %0d got %0d, status exp %0d got %0d",
                           $signed(expected.range_sum), $signed(sum),
                           expected.status, status);
               end
            end
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CNT_BITS-1:0]    csr_data = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // element_index, new_value, range_left, range_right, zero pad
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   // operation
   logic [0:0]             req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // range_sum, zero pad
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   // status
   logic [0:0]             rsp_tuser;

   range_sum_tracker sum_board = new();

   bit          no_gaps = 1'b0;   // set for stretches with no idling on either side
   int          stall_left = 0;   // remaining stall cycles on the result side
   int unsigned cycle_count = 0;

   segment_tree_range_sum_core #(
      .CAPACITY   (CAPACITY),
      .VALUE_BITS (VAL_BITS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // idle length: mostly none or short, now and then a long one
   function automatic int pick_gap();
      int roll;
      if (no_gaps) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // values lean on the extremes so the 42-bit sums see carries and sign
   function automatic logic [VAL_BITS-1:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 20) - 10;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type build_item(logic op, int idx, logic [VAL_BITS-1:0] value,
                                          int left, int right);
      req_type item;
      item.operation     = op;
      item.element_index = IDX_BITS'(idx);
      item.new_value     = value;
      item.range_left    = IDX_BITS'(left);
      item.range_right   = IDX_BITS'(right);
      return item;
   endfunction

   // random request; mostly well-formed for the live count, some out of range,
   // some reversed, some narrow
   function automatic req_type random_item(int unsigned live);
      req_type item;
      int      roll;
      int      swap;
      item = build_item(1'($urandom_range(0, 1)), $urandom_range(0, CAPACITY - 1),
                        pick_value(), $urandom_range(0, CAPACITY - 1),
                        $urandom_range(0, CAPACITY - 1));
      roll = $urandom_range(0, 99);
      if (live == 0) return item;   // everything is an error anyway
      if (roll < 10 && live < CAPACITY) begin
         item.element_index = IDX_BITS'($urandom_range(live, CAPACITY - 1));
         if ($urandom_range(0, 1)) begin
            item.range_left = IDX_BITS'($urandom_range(live, CAPACITY - 1));
         end else begin
            item.range_right = IDX_BITS'($urandom_range(live, CAPACITY - 1));
         end
         return item;
      end
      item.element_index = IDX_BITS'($urandom_range(0, live - 1));
      item.range_left    = IDX_BITS'($urandom_range(0, live - 1));
      item.range_right   = IDX_BITS'($urandom_range(0, live - 1));
      if (roll < 25) begin
         swap = item.range_left + $urandom_range(0, 7);
         item.range_right = IDX_BITS'((swap > live - 1) ? live - 1 : swap);
      end else if ((roll < 35) == (item.range_left < item.range_right)) begin
         // reversed ranges on purpose for a slice, ordered ones otherwise
         swap             = item.range_left;
         item.range_left  = item.range_right;
         item.range_right = IDX_BITS'(swap);
      end
      return item;
   endfunction

   // one request transaction; valid stays high straight into the next one
   // when there is no gap
   task automatic send_item(req_type item);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, item.range_right, item.range_left, item.new_value,
                     item.element_index};
      req_tuser  <= item.operation;
      do @(posedge clock); while (!req_tready);
      sum_board.note_request(item);
   endtask

   // stop requests and wait until every owed result has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (!sum_board.idle()) @(posedge clock);
   endtask

   // count register is only written with nothing in flight
   task automatic write_count(logic [CNT_BITS-1:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sum_board.set_count(value);
   endtask

   // result side: check every accepted transaction, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sum_board.check_result(rsp_tdata[SUM_BITS-1:0], rsp_tuser[0]);
      end
      if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
         stall_left = pick_gap();
      end
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // watchdog; covers the memory clearing pass after reset with a wide margin
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int unsigned phase_counts [7];
      int unsigned live;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes at the default count of 1024
      send_item(build_item(OP_SET, 0, 32'h7fff_ffff, 0, 0));
      send_item(build_item(OP_SET, 1023, 32'h8000_0000, 1023, 1023));
      send_item(build_item(OP_SET, 512, 32'hffff_ffff, 0, 0));
      send_item(build_item(OP_SET, 1, 32'h7fff_ffff, 0, 0));
      send_item(build_item(OP_QUERY, 0, 0, 0, 1023));
      send_item(build_item(OP_QUERY, 0, 0, 0, 0));
      send_item(build_item(OP_QUERY, 0, 0, 1023, 1023));
      // two maximal values overflow 32 bits
      send_item(build_item(OP_QUERY, 0, 0, 0, 1));
      // reversed range, both bounds valid
      send_item(build_item(OP_QUERY, 0, 0, 700, 300));
      send_item(build_item(OP_SET, 511, 32'h8000_0000, 0, 0));

      // oversized count saturates to capacity
      write_count(11'd2047);
      send_item(build_item(OP_QUERY, 0, 0, 1, 1023));
      send_item(build_item(OP_SET, 1023, 32'h1234_5678, 0, 0));

      // zero count: every transaction is a range error
      write_count(11'd0);
      send_item(build_item(OP_SET, 0, 32'h0000_0005, 0, 0));
      send_item(build_item(OP_QUERY, 0, 0, 0, 0));

      // single element
      write_count(11'd1);
      send_item(build_item(OP_SET, 0, -32'sd5, 0, 0));
      send_item(build_item(OP_SET, 1, 32'h0000_0009, 0, 0));
      send_item(build_item(OP_QUERY, 0, 0, 0, 0));
      send_item(build_item(OP_QUERY, 0, 0, 0, 1));
      // left out of range wins over the reversed-range case
      send_item(build_item(OP_QUERY, 0, 0, 1, 0));

      // shrunk count: rejected update leaves the store alone
      write_count(11'd600);
      send_item(build_item(OP_SET, 900, 32'h7fff_ffff, 0, 0));
      send_item(build_item(OP_QUERY, 0, 0, 512, 599));
      send_item(build_item(OP_QUERY, 0, 0, 599, 0));

      // grown back: elements past the old count still hold their values
      write_count(11'd1024);
      send_item(build_item(OP_QUERY, 0, 0, 0, 1023));
      send_item(build_item(OP_QUERY, 0, 0, 900, 1023));

      // random phases over several counts, two of them without idling
      phase_counts = '{1024, 2047, 1, 40, 0, 0, 1024};
      phase_counts[4] = $urandom_range(2, 1023);
      phase_counts[5] = $urandom_range(1025, 2047);
      foreach (phase_counts[p]) begin
         write_count(CNT_BITS'(phase_counts[p]));
         live    = (phase_counts[p] > CAPACITY) ? CAPACITY : phase_counts[p];
         no_gaps = (p == 2 || p == 5);
         repeat (PHASE_ITEMS) send_item(random_item(live));
      end
      no_gaps = 1'b0;

      drain_results();
      repeat (40) @(posedge clock);
      if (sum_board.mismatches == 0 && sum_board.idle()) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
